/* hdl/cpfm_pkg.sv */
// shared types and constants for the collision pair filter matrix
`timescale 1ns / 1ps
package cpfm_pkg;

	localparam int MAX_TYPES_DEFAULT = 32;
	localparam int FUNC_W = 3;
	localparam int TYPE_W = 5;
	localparam int MASK_W = 32;
	localparam int CNT_W  = 6;

	localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET_EN = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_PAIR   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_MASK   = 3'd5;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TYPE_W-1:0] type_a;
		logic [TYPE_W-1:0] type_b;
		logic              enable_flag;
		logic [MASK_W-1:0] mask_a;
		logic [MASK_W-1:0] mask_b;
	} req_t;

	typedef struct packed {
		logic             answer;
		logic [CNT_W-1:0] type_count;
	} rsp_t;

endpackage

/* hdl/cpfm_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module cpfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/collision_pair_filter_matrix_core.sv */
// top level of the collision pair filter matrix
`timescale 1ns / 1ps
// Keeps a symmetric pair matrix of collision types, one enable bit per type
// and the count of types in use. A request is taken on a rising edge with
// start high and busy low; req carries the operation and its operands.
// Each request gives exactly one response on rsp, marked by done for one
// cycle; the receiver cannot hold it off.
// Set enable, rejected edits, queries out of range or on a disabled type and
// unused codes answer in the cycle after the request and leave busy low. Add,
// remove, set pair, query and mask test otherwise walk the pair-row ram,
// one row issued per cycle into a registered read and a read-modify-write
// stage, as the ram has a single read port. busy stays high until done.
// After reset the count is one, every type is enabled and only the pair of
// type zero with itself is set; row valid bits make unwritten rows read as
// their reset value, so no clearing pass is needed.
module collision_pair_filter_matrix_core #(
	parameter int MAX_TYPES = cpfm_pkg::MAX_TYPES_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cpfm_pkg::req_t req,
	output logic           done,
	output cpfm_pkg::rsp_t rsp
);

	localparam int W  = MAX_TYPES;
	localparam int AW = $clog2(MAX_TYPES);
	localparam int CW = cpfm_pkg::CNT_W;

	typedef logic [W-1:0]  row_t;
	typedef logic [AW-1:0] addr_t;

	logic                        busy_q, done_q;
	cpfm_pkg::rsp_t              rsp_q;
	logic [cpfm_pkg::FUNC_W-1:0] op_q;
	logic [cpfm_pkg::TYPE_W-1:0] ta_q, tb_q;
	logic                        flag_q;
	row_t                        ma_q, mb_q;
	logic [CW-1:0]               cnt_q;
	row_t                        en_q, valid_q;
	logic                        iss_q, hit_q;
	addr_t                       k_q, last_q;

	logic  vld_s1, first_s1, last_s1, rowv_s1;
	addr_t addr_s1;

	logic  wr_q;
	addr_t waddr_q;
	row_t  wdata_q;

	logic           accept;
	logic           walk, imm_ans;
	addr_t          walk_last;
	logic [CW-1:0]  ta_ext, tb_ext, max_ext;
	addr_t          rd_addr, ni;
	row_t           rdata, row_rd, row_new, cmask, rmv_mask, bit_sel;
	logic           we, hit_now, fin_ans;

	assign accept  = start && !busy_q;
	assign ta_ext  = CW'(req.type_a);
	assign tb_ext  = CW'(req.type_b);
	assign max_ext = CW'(MAX_TYPES);
	assign ni      = AW'(cnt_q - CW'(1));

	always_comb begin
		for (int j = 0; j < W; j++) begin
			cmask[j]    = (CW'(j) < cnt_q);
			rmv_mask[j] = (CW'(j) < (cnt_q - CW'(1)));
		end
	end

	// decide at request time whether the op walks the ram
	always_comb begin
		walk      = 1'b0;
		imm_ans   = 1'b0;
		walk_last = '0;
		unique case (req.func)
			cpfm_pkg::FUNC_ADD: begin
				walk      = (cnt_q < max_ext);
				walk_last = AW'(cnt_q);
			end
			cpfm_pkg::FUNC_REMOVE: begin
				walk      = (cnt_q > CW'(1));
				walk_last = AW'(cnt_q - CW'(2));
			end
			cpfm_pkg::FUNC_SET_EN: begin
				imm_ans = (ta_ext < cnt_q);
			end
			cpfm_pkg::FUNC_PAIR: begin
				walk      = (ta_ext < max_ext) && (tb_ext < max_ext);
				walk_last = AW'(1);
			end
			cpfm_pkg::FUNC_QUERY: begin
				walk = (ta_ext < cnt_q) && (tb_ext < cnt_q)
					&& en_q[AW'(req.type_a)] && en_q[AW'(req.type_b)];
			end
			cpfm_pkg::FUNC_MASK: begin
				walk      = 1'b1;
				walk_last = AW'(cnt_q - CW'(1));
			end
			default: begin
				imm_ans = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (op_q == cpfm_pkg::FUNC_PAIR) begin
			rd_addr = (k_q == '0) ? AW'(ta_q) : AW'(tb_q);
		end else if (op_q == cpfm_pkg::FUNC_QUERY) begin
			rd_addr = AW'(ta_q);
		end else begin
			rd_addr = k_q;
		end
	end

	cpfm_ram #(
		.WIDTH(W),
		.DEPTH(MAX_TYPES)
	) u_rows (
		.clk  (clk),
		.we   (we),
		.waddr(addr_s1),
		.wdata(row_new),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// forward last write, else fall back to reset value for unwritten rows
	always_comb begin
		if (wr_q && (waddr_q == addr_s1)) begin
			row_rd = wdata_q;
		end else if (rowv_s1) begin
			row_rd = rdata;
		end else begin
			row_rd = (addr_s1 == '0) ? row_t'(1) : '0;
		end
	end

	always_comb begin
		bit_sel = first_s1 ? (row_t'(1) << AW'(tb_q)) : (row_t'(1) << AW'(ta_q));
		row_new = row_rd;
		we      = 1'b0;
		unique case (op_q)
			cpfm_pkg::FUNC_ADD: begin
				row_new = row_rd | (row_t'(1) << ni) | ((addr_s1 == ni) ? cmask : '0);
				we      = vld_s1;
			end
			cpfm_pkg::FUNC_REMOVE: begin
				row_new = row_rd & cmask;
				we      = vld_s1;
			end
			cpfm_pkg::FUNC_PAIR: begin
				row_new = flag_q ? (row_rd | bit_sel) : (row_rd & ~bit_sel);
				we      = vld_s1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign hit_now = ma_q[addr_s1] && en_q[addr_s1] && (|(row_rd & mb_q & en_q & cmask));

	always_comb begin
		if (op_q == cpfm_pkg::FUNC_QUERY) begin
			fin_ans = row_rd[AW'(tb_q)];
		end else if (op_q == cpfm_pkg::FUNC_MASK) begin
			fin_ans = hit_q || hit_now;
		end else begin
			fin_ans = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= CW'(1);
			en_q    <= '1;
			valid_q <= '0;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
			wr_q    <= 1'b0;
			hit_q   <= 1'b0;
			op_q    <= '0;
			k_q     <= '0;
		end else begin
			done_q <= (vld_s1 && last_s1) || (accept && !walk);
			wr_q   <= we;
			vld_s1 <= iss_q;
			if (we) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (vld_s1 && op_q == cpfm_pkg::FUNC_MASK) begin
				hit_q <= hit_q || hit_now;
			end
			if (iss_q) begin
				k_q <= k_q + AW'(1);
				if (k_q == last_q) begin
					iss_q <= 1'b0;
				end
			end
			if (vld_s1 && last_s1) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				op_q  <= req.func;
				hit_q <= 1'b0;
				k_q   <= '0;
				if (walk) begin
					busy_q <= 1'b1;
					iss_q  <= 1'b1;
				end
				if (req.func == cpfm_pkg::FUNC_ADD && walk) begin
					cnt_q              <= cnt_q + CW'(1);
					en_q[AW'(cnt_q)]   <= 1'b1;
				end
				if (req.func == cpfm_pkg::FUNC_REMOVE && walk) begin
					cnt_q   <= cnt_q - CW'(1);
					valid_q <= valid_q & rmv_mask;
				end
				if (req.func == cpfm_pkg::FUNC_SET_EN && imm_ans) begin
					en_q[AW'(req.type_a)] <= req.enable_flag;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ta_q   <= req.type_a;
			tb_q   <= req.type_b;
			flag_q <= req.enable_flag;
			ma_q   <= req.mask_a[W-1:0];
			mb_q   <= req.mask_b[W-1:0];
			last_q <= walk_last;
			rsp_q.answer     <= imm_ans;
			rsp_q.type_count <= cnt_q;
		end
		if (vld_s1 && last_s1) begin
			rsp_q.answer     <= fin_ans;
			rsp_q.type_count <= cnt_q;
		end
		addr_s1  <= rd_addr;
		first_s1 <= (k_q == '0);
		last_s1  <= (k_q == last_q);
		rowv_s1  <= valid_q[rd_addr];
		waddr_q  <= addr_s1;
		wdata_q  <= row_new;
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("response while walk in progress");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(1)) && (cnt_q <= CW'(MAX_TYPES)))
		else $error("type count out of range");

	a_cnt_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(cnt_q))
		else $error("type count moved during walk");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		iss_q |-> busy_q)
		else $error("row issued outside a walk");

	a_write_stage: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (vld_s1 && busy_q))
		else $error("row write without a read in flight");

endmodule

/* dv/collision_pair_filter_matrix_core_tb.sv */
// testbench for the collision pair filter matrix core: predicted responses checked in order
`timescale 1ns / 1ps
module collision_pair_filter_matrix_core_tb;

	localparam int MAX_TYPES = cpfm_pkg::MAX_TYPES_DEFAULT;
	localparam int CLK_PERIOD = 12;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_MAX = 10;
	localparam logic [cpfm_pkg::FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [cpfm_pkg::FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	typedef struct packed {
		cpfm_pkg::req_t r;
		logic           hold_for_drain;
	} pending_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cpfm_pkg::req_t req = '0;
	logic busy;
	logic done;
	cpfm_pkg::rsp_t rsp;

	pending_req_t   pending_q[$];
	cpfm_pkg::rsp_t expected_rsp_q[$];

	// matrix state as the block should hold it
	logic [cpfm_pkg::MASK_W-1:0] pair_rows [32];
	logic                        type_en [32];
	int unsigned                 type_cnt;

	int  plan_cnt;
	bit  hold_next;
	bit  taken;
	int  idle_pct;
	int  mismatch_cnt;
	int  cycle_cnt;

	collision_pair_filter_matrix_core #(
		.MAX_TYPES(MAX_TYPES)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [cpfm_pkg::MASK_W-1:0] low_bits(int unsigned n);
		if (n >= 32)
			return '1;
		return (32'd1 << n) - 32'd1;
	endfunction

	function automatic bit pair_enabled(int unsigned a, int unsigned b);
		if (a >= type_cnt || b >= type_cnt)
			return 1'b0;
		if (!type_en[a] || !type_en[b])
			return 1'b0;
		return pair_rows[a][b];
	endfunction

	function automatic cpfm_pkg::rsp_t run_matrix_op(cpfm_pkg::req_t r);
		cpfm_pkg::rsp_t o;
		int unsigned    ni;
		int unsigned    a;
		int unsigned    b;
		o = '0;
		a = r.type_a;
		b = r.type_b;
		unique case (r.func)
			cpfm_pkg::FUNC_ADD: begin
				if (type_cnt < MAX_TYPES) begin
					ni = type_cnt;
					type_en[ni] = 1'b1;
					type_cnt = ni + 1;
					for (int i = 0; i < type_cnt; i++) begin
						pair_rows[i][ni] = 1'b1;
						pair_rows[ni][i] = 1'b1;
					end
					o.answer = 1'b1;
				end
			end
			cpfm_pkg::FUNC_REMOVE: begin
				if (type_cnt > 1) begin
					type_cnt = type_cnt - 1;
					for (int i = 0; i < 32; i++) begin
						if (i < type_cnt)
							pair_rows[i] = pair_rows[i] & low_bits(type_cnt);
						else
							pair_rows[i] = '0;
					end
					o.answer = 1'b1;
				end
			end
			cpfm_pkg::FUNC_SET_EN: begin
				if (a < type_cnt) begin
					type_en[a] = r.enable_flag;
					o.answer = 1'b1;
				end
			end
			cpfm_pkg::FUNC_PAIR: begin
				if (a < MAX_TYPES && b < MAX_TYPES) begin
					pair_rows[a][b] = r.enable_flag;
					pair_rows[b][a] = r.enable_flag;
					o.answer = 1'b1;
				end
			end
			cpfm_pkg::FUNC_QUERY: o.answer = pair_enabled(a, b);
			cpfm_pkg::FUNC_MASK: begin
				for (int i = 0; i < type_cnt; i++)
					for (int j = 0; j < type_cnt; j++)
						if (r.mask_a[i] && r.mask_b[j] && pair_enabled(i, j))
							o.answer = 1'b1;
			end
			default: o.answer = 1'b0;
		endcase
		o.type_count = type_cnt[cpfm_pkg::CNT_W-1:0];
		return o;
	endfunction

	// requests are planned ahead, so the generator tracks the count on its own
	task automatic push_op(input logic [cpfm_pkg::FUNC_W-1:0] f, input int ta,
			input int tb, input bit flag, input logic [cpfm_pkg::MASK_W-1:0] ma,
			input logic [cpfm_pkg::MASK_W-1:0] mb);
		pending_req_t p;
		p.r.func = f;
		p.r.type_a = ta[cpfm_pkg::TYPE_W-1:0];
		p.r.type_b = tb[cpfm_pkg::TYPE_W-1:0];
		p.r.enable_flag = flag;
		p.r.mask_a = ma;
		p.r.mask_b = mb;
		p.hold_for_drain = hold_next;
		hold_next = 1'b0;
		pending_q = {pending_q, p};
		if (f == cpfm_pkg::FUNC_ADD && plan_cnt < MAX_TYPES)
			plan_cnt++;
		if (f == cpfm_pkg::FUNC_REMOVE && plan_cnt > 1)
			plan_cnt--;
	endtask

	function automatic int pick_type();
		if ($urandom_range(0, 99) < 75)
			return $urandom_range(0, plan_cnt - 1);
		return $urandom_range(0, 31);
	endfunction

	function automatic logic [cpfm_pkg::MASK_W-1:0] pick_mask();
		unique case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'd1 << $urandom_range(0, 31);
			2: return $urandom & $urandom & $urandom;
			3: return '0;
			4: return '1;
			default: return $urandom & low_bits(plan_cnt);
		endcase
	endfunction

	task automatic push_random(input int n);
		bit                          growing;
		int                          r;
		int                          add_w;
		int                          rem_w;
		logic [cpfm_pkg::FUNC_W-1:0] f;
		growing = 1'b1;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 39) == 0)
				growing = ~growing;
			add_w = growing ? 22 : 8;
			rem_w = growing ? 8 : 22;
			r = $urandom_range(0, 99);
			if (r < add_w)
				f = cpfm_pkg::FUNC_ADD;
			else if (r < 30)
				f = cpfm_pkg::FUNC_REMOVE;
			else if (r < 44)
				f = cpfm_pkg::FUNC_SET_EN;
			else if (r < 62)
				f = cpfm_pkg::FUNC_PAIR;
			else if (r < 78)
				f = cpfm_pkg::FUNC_QUERY;
			else if (r < 96)
				f = cpfm_pkg::FUNC_MASK;
			else if (r < 98)
				f = FUNC_SPARE_LO;
			else
				f = FUNC_SPARE_HI;
			push_op(f, pick_type(), pick_type(), 1'($urandom_range(0, 1)), pick_mask(),
				pick_mask());
		end
	endtask

	task automatic push_phase();
		push_random(200);
		while (plan_cnt < MAX_TYPES)
			push_op(cpfm_pkg::FUNC_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
				1'($urandom_range(0, 1)), $urandom, $urandom);
		// add when already full
		push_op(cpfm_pkg::FUNC_ADD, 0, 0, 1'b0, '0, '0);
		push_random(150);
		hold_next = 1'b1;
		while (plan_cnt > 1)
			push_op(cpfm_pkg::FUNC_REMOVE, $urandom_range(0, 31), $urandom_range(0, 31),
				1'($urandom_range(0, 1)), $urandom, $urandom);
		// remove with a single type left
		push_op(cpfm_pkg::FUNC_REMOVE, 0, 0, 1'b0, '0, '0);
		push_random(200);
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			if (pending_q.size() == 0)
				start <= 1'b0;
			else if (pending_q[0].hold_for_drain && expected_rsp_q.size() != 0)
				start <= 1'b0;
			else if ($urandom_range(0, 99) < idle_pct)
				start <= 1'b0;
			else begin
				req <= pending_q[0].r;
				pending_q.pop_front();
				start <= 1'b1;
			end
		end
	end

	// acceptance and response check
	always @(posedge clk) begin
		cpfm_pkg::rsp_t want;
		taken = arst_n && start && !busy;
		if (taken)
			expected_rsp_q = {expected_rsp_q, run_matrix_op(req)};
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("unexpected response answer=%0d type_count=%0d",
						rsp.answer, rsp.type_count);
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.answer !== want.answer || rsp.type_count !== want.type_count) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display({"response error: answer exp %0d got %0d, ",
							"type_count exp %0d got %0d"},
							want.answer, rsp.answer, want.type_count, rsp.type_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("collision_pair_filter_matrix_core: mismatch");
			$finish;
		end
	end

	initial begin
		mismatch_cnt = 0;
		cycle_cnt = 0;
		taken = 1'b0;
		hold_next = 1'b0;
		idle_pct = 38;
		for (int i = 0; i < 32; i++) begin
			pair_rows[i] = '0;
			type_en[i] = 1'b1;
		end
		pair_rows[0] = 32'd1;
		type_cnt = 1;
		plan_cnt = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		push_op(cpfm_pkg::FUNC_QUERY, 0, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_MASK, 0, 0, 1'b0, 32'h1, 32'h1);
		push_op(cpfm_pkg::FUNC_REMOVE, 0, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_SET_EN, 1, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_PAIR, 5, 7, 1'b1, '0, '0);
		push_op(cpfm_pkg::FUNC_QUERY, 5, 7, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_ADD, 0, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_QUERY, 0, 1, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_SET_EN, 1, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_QUERY, 1, 0, 1'b1, '0, '0);
		push_op(cpfm_pkg::FUNC_MASK, 0, 0, 1'b0, 32'h1, 32'h2);
		push_op(cpfm_pkg::FUNC_SET_EN, 1, 0, 1'b1, '0, '0);
		push_op(cpfm_pkg::FUNC_MASK, 0, 0, 1'b0, 32'hFFFF_FFF8, 32'hFFFF_FFF8);
		push_op(cpfm_pkg::FUNC_MASK, 0, 0, 1'b0, 32'hFFFF_FFFC, '1);
		push_op(cpfm_pkg::FUNC_PAIR, 0, 1, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_QUERY, 1, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_PAIR, 31, 31, 1'b1, '0, '0);
		push_op(cpfm_pkg::FUNC_MASK, 31, 31, 1'b1, '1, '1);
		push_op(FUNC_SPARE_LO, 31, 31, 1'b1, '1, '1);
		push_op(FUNC_SPARE_HI, 31, 31, 1'b1, '1, '1);
		push_op(cpfm_pkg::FUNC_ADD, 0, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_REMOVE, 0, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_REMOVE, 0, 0, 1'b0, '0, '0);
		push_op(cpfm_pkg::FUNC_QUERY, 0, 0, 1'b0, '0, '0);

		push_phase();
		wait_drained();
		@(posedge clk);
		idle_pct = 76;
		push_phase();
		wait_drained();
		@(posedge clk);
		idle_pct = 0;
		push_phase();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && expected_rsp_q.size() == 0)
			$display("collision_pair_filter_matrix_core: match");
		else
			$display("collision_pair_filter_matrix_core: mismatch");
		$finish;
	end

endmodule
